[hdl/wbps_pkg.sv]
// shared types and constants for the wildcard byte pattern scanner
// no dependencies

package wbps_pkg;

  localparam int SIG_BYTES  = 32;
  localparam int ADDR_W     = 48;
  localparam int LEN_W      = 6;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

  // register indexes, each register at byte address 8*index
  localparam logic [REG_IDX_W-1:0] REG_LENGTH = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WORD_0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WORD_1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WORD_2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WORD_3 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CARE   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BASE   = 3'd6;

  typedef struct packed {
    logic [LEN_W-1:0]         length;
    logic [SIG_BYTES*8-1:0]   sig;
    logic [SIG_BYTES-1:0]     care;
    logic [ADDR_W-1:0]        base;
  } cfg_t;

endpackage

[hdl/wbps_cfg.sv]
// configuration register file behind the apb-style port
// depends on wbps_pkg

module wbps_cfg import wbps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.length <= LEN_W'(1);
      cfg.sig    <= '0;
      cfg.care   <= '0;
      cfg.base   <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_LENGTH: cfg.length        <= pwdata[LEN_W-1:0];
        REG_WORD_0: cfg.sig[63:0]     <= pwdata;
        REG_WORD_1: cfg.sig[127:64]   <= pwdata;
        REG_WORD_2: cfg.sig[191:128]  <= pwdata;
        REG_WORD_3: cfg.sig[255:192]  <= pwdata;
        REG_CARE:   cfg.care          <= pwdata[SIG_BYTES-1:0];
        REG_BASE:   cfg.base          <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LENGTH: prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, cfg.length};
      REG_WORD_0: prdata = cfg.sig[63:0];
      REG_WORD_1: prdata = cfg.sig[127:64];
      REG_WORD_2: prdata = cfg.sig[191:128];
      REG_WORD_3: prdata = cfg.sig[255:192];
      REG_CARE:   prdata = {{(CFG_DATA_W-SIG_BYTES){1'b0}}, cfg.care};
      REG_BASE:   prdata = {{(CFG_DATA_W-ADDR_W){1'b0}}, cfg.base};
      default:    prdata = '0;
    endcase
  end

endmodule

[hdl/wbps_match.sv]
// parallel masked compare of the window against the signature
// depends on wbps_pkg

module wbps_match import wbps_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  logic [PATTERN_MAX-1:0][7:0] window,
  input  logic [LEN_W-1:0]            length,
  input  logic [SIG_BYTES*8-1:0]      sig,
  input  logic [SIG_BYTES-1:0]        care,
  output logic                        hit
);

  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [SIG_BYTES-1:0] lane_ok;

  // signature byte i lines up with window slot length-1-i (slot 0 is newest)
  always_comb begin
    logic [LEN_W-1:0] slot;
    logic [7:0]       got;
    for (int i = 0; i < SIG_BYTES; i++) begin
      slot = length - LEN_W'(i) - LEN_W'(1);
      if (LEN_W'(i) < length) begin
        got        = window[slot[IDX_W-1:0]];
        lane_ok[i] = !care[i] || (got == sig[8*i +: 8]);
      end else begin
        got        = 8'd0;
        lane_ok[i] = 1'b1;
      end
    end
  end

  assign hit = &lane_ok;

endmodule

[hdl/wildcard_byte_pattern_scan_top.sv]
// top level of the wildcard byte pattern scanner
// depends on wbps_pkg, wbps_cfg, wbps_match
//
//   channel   valid         stall         payload
//   item      item_valid    item_stall    data_byte, last_byte
//   result    result_valid  result_stall  found, match_address
//   config    apb write (psel, penable, pwrite, pready), 8-byte register slots
//
// one byte is taken every cycle while item_stall is low; the masked compare over the whole window and
// the match address add sit between the window registers and the result register
// a result shows in the cycle after the item that caused it
// item_stall rises only while a finished result waits and result_stall is high
// rst is synchronous: window, byte count and found flag clear, registers take
// their reset values

module wildcard_byte_pattern_scan_top import wbps_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // byte stream in
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  // result out
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic                  found,
  output logic [ADDR_W-1:0]     match_address
);

  // longest usable signature
  localparam int CAP = (PATTERN_MAX < SIG_BYTES) ? PATTERN_MAX : SIG_BYTES;

  cfg_t cfg;

  // scan state
  logic [PATTERN_MAX-1:0][7:0] window;
  logic [PATTERN_MAX-1:0][7:0] window_next;
  logic [ADDR_W-1:0]           byte_count;
  logic [ADDR_W-1:0]           byte_count_next;
  logic                        already_found;

  logic             accept;
  logic [LEN_W-1:0] eff_len;
  logic             lane_hit;
  logic             enough;
  logic             hit;
  logic             emit;

  wbps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // a zero length acts as one, anything past the window depth or the signature size is clipped
  always_comb begin
    if (cfg.length == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg.length > LEN_W'(CAP)) begin
      eff_len = LEN_W'(CAP);
    end else begin
      eff_len = cfg.length;
    end
  end

  // shift the new byte in at slot 0
  always_comb begin
    window_next[0] = data_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      window_next[k] = window[k-1];
    end
  end

  // byte count saturates at all ones
  assign byte_count_next = (byte_count == ADDR_MAX) ? byte_count
                                                    : byte_count + ADDR_W'(1);

  wbps_match #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_match (
    .window (window_next),
    .length (eff_len),
    .sig    (cfg.sig),
    .care   (cfg.care),
    .hit    (lane_hit)
  );

  // compare only once the window holds a full signature
  assign enough = byte_count_next >= {{(ADDR_W-LEN_W){1'b0}}, eff_len};
  assign hit    = !already_found && enough && lane_hit;
  // first match, or end of region with nothing found
  assign emit   = hit || (!already_found && last_byte);

  // the result register is the only thing that can hold up the stream
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      byte_count    <= '0;
      already_found <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        // region done, next byte starts fresh
        window        <= '0;
        byte_count    <= '0;
        already_found <= 1'b0;
      end else begin
        window        <= window_next;
        byte_count    <= byte_count_next;
        already_found <= already_found || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // payload holds while stalled since a new item cannot be accepted then
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      found         <= hit;
      match_address <= hit ? cfg.base + byte_count_next
                             - {{(ADDR_W-LEN_W){1'b0}}, eff_len}
                           : '0;
    end
  end

endmodule

[hdl/wbps_checker.sv]
// port-level checks for the wildcard byte pattern scanner
// depends on wbps_pkg, bound to wildcard_byte_pattern_scan_top

module wbps_checker import wbps_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              last_byte,
  input logic              result_valid,
  input logic              result_stall,
  input logic              found,
  input logic [ADDR_W-1:0] match_address
);

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(found)
                                     && $stable(match_address))
    else $error("stalled result changed");

  // not-found carries a zero address
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> match_address == '0)
    else $error("not-found result with nonzero address");

  // the stream stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("item stall without pending result");

  // every fresh result comes from the item accepted in the cycle before
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_valid && !$past(result_valid && result_stall)
      |-> $past(item_valid && !item_stall))
    else $error("result without an accepted item");

  // a not-found result only follows the final byte of a region
  a_notfound_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found && !$past(result_valid && result_stall)
      |-> $past(last_byte))
    else $error("not-found result before end of region");

endmodule

bind wildcard_byte_pattern_scan_top wbps_checker u_wbps_checker (.*);

[dv/pattern_scan_checker.sv]
// predicts and checks the result items of the wildcard byte pattern scanner
// watches the config writes, the byte channel and the result channel
// depends on wbps_pkg
`timescale 1ns / 100ps

module pattern_scan_checker import wbps_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  logic                  found,
  input  logic [ADDR_W-1:0]     match_address,
  output int                    mismatches,
  output int                    reports_due
);

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } scan_report_t;

  cfg_t              regs;
  logic [7:0]        recent [SIG_BYTES];
  logic [ADDR_W-1:0] seen_bytes;
  logic              matched;
  scan_report_t      expected_reports [$];
  int                errs = 0;

  // length in force: zero acts as one, the top is capped
  function automatic int unsigned active_length(input logic [LEN_W-1:0] len);
    int unsigned cap;
    int unsigned n;
    cap = (PATTERN_MAX < SIG_BYTES) ? PATTERN_MAX : SIG_BYTES;
    n = (len == '0) ? 1 : len;
    if (n > cap) n = cap;
    return n;
  endfunction

  // recent[0] is the newest byte, signature byte 0 lines up with the oldest
  function automatic logic window_hit(input int unsigned n);
    if (seen_bytes < ADDR_W'(n)) return 1'b0;
    for (int i = 0; i < n; i++)
      if (regs.care[i] && recent[n-1-i] != regs.sig[i*8 +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic clear_region();
    for (int i = 0; i < SIG_BYTES; i++) recent[i] = 8'h00;
    seen_bytes = '0;
    matched = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic lst);
    int unsigned n;
    scan_report_t r;
    n = active_length(regs.length);
    for (int i = SIG_BYTES - 1; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = b;
    if (seen_bytes != ADDR_MAX) seen_bytes = seen_bytes + 1'b1;
    if (!matched && window_hit(n)) begin
      matched = 1'b1;
      r.hit = 1'b1;
      r.addr = regs.base + seen_bytes - ADDR_W'(n);
      expected_reports = {expected_reports, r};
    end else if (!matched && lst) begin
      r.hit = 1'b0;
      r.addr = '0;
      expected_reports = {expected_reports, r};
    end
    if (lst) clear_region();
  endtask

  task automatic apply_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_LENGTH: regs.length = d[LEN_W-1:0];
      REG_WORD_0: regs.sig[0   +: 64] = d;
      REG_WORD_1: regs.sig[64  +: 64] = d;
      REG_WORD_2: regs.sig[128 +: 64] = d;
      REG_WORD_3: regs.sig[192 +: 64] = d;
      REG_CARE:   regs.care = d[SIG_BYTES-1:0];
      REG_BASE:   regs.base = d[ADDR_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    scan_report_t want;
    if (rst) begin
      regs = '0;
      regs.length = LEN_W'(1);
      clear_region();
      expected_reports.delete();
    end else begin
      // results first: an item taken at this edge cannot have a result yet
      if (result_valid && !result_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result item found=%0b match_address=%h",
                   $time, found, match_address);
          errs++;
        end else begin
          want = expected_reports.pop_front();
          if (found !== want.hit) begin
            $display("%0t: found expected %0b actual %0b", $time, want.hit, found);
            errs++;
          end
          if (match_address !== want.addr) begin
            $display("%0t: match_address expected %h actual %h",
                     $time, want.addr, match_address);
            errs++;
          end
        end
      end
      if (item_valid && !item_stall) scan_byte(data_byte, last_byte);
      if (psel && penable && pwrite && pready)
        apply_write(paddr[CFG_ADDR_W-1:3], pwdata);
    end
    mismatches <= errs;
    reports_due <= expected_reports.size();
  end

endmodule

[dv/wildcard_byte_pattern_scan_top_tb.sv]
// testbench top for the wildcard byte pattern scanner: clock, reset, stimulus, verdict
// depends on wbps_pkg, wildcard_byte_pattern_scan_top and pattern_scan_checker
`timescale 1ns / 100ps

module wildcard_byte_pattern_scan_top_tb import wbps_pkg::*;;

  localparam int SCAN_ITEMS  = 570;   // directed plus about 550 random bytes
  localparam int HOLD_CYCLES = 90;    // long receiver hold-off
  localparam int IDLE_PCT    = 14;

  typedef enum {PLANTED, NOISE, BROKEN} region_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic [7:0]            data_byte = 8'h00;
  logic                  last_byte = 1'b0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic                  found;
  logic [ADDR_W-1:0]     match_address;
  int                    mismatches;
  int                    reports_due;

  // stimulus copy of the signature, only used to plant matches in regions
  logic [SIG_BYTES*8-1:0] sig_bits = '0;
  logic [SIG_BYTES-1:0]   care_bits = '0;
  int unsigned            span = 1;
  logic [7:0]             region [$];
  int                     items_sent = 0;
  bit                     calm = 1'b0;     // no idling on either side while set
  int                     hold_req = 0;    // bumped to ask the receiver for a hold-off
  int                     hold_seen = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wildcard_byte_pattern_scan_top dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .item_valid, .item_stall, .data_byte, .last_byte,
    .result_valid, .result_stall, .found, .match_address
  );

  pattern_scan_checker u_scan_check (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .item_valid, .item_stall, .data_byte, .last_byte,
    .result_valid, .result_stall, .found, .match_address,
    .mismatches, .reports_due
  );

  // apb write: setup cycle, then access until pready
  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // writes every register, then keeps the stimulus copy in step
  task automatic program_scan(input logic [LEN_W-1:0] len,
                              input logic [SIG_BYTES*8-1:0] sig,
                              input logic [SIG_BYTES-1:0] care,
                              input logic [ADDR_W-1:0] base);
    set_reg(REG_LENGTH, CFG_DATA_W'(len));
    set_reg(REG_WORD_0, sig[0   +: 64]);
    set_reg(REG_WORD_1, sig[64  +: 64]);
    set_reg(REG_WORD_2, sig[128 +: 64]);
    set_reg(REG_WORD_3, sig[192 +: 64]);
    set_reg(REG_CARE, CFG_DATA_W'(care));
    set_reg(REG_BASE, CFG_DATA_W'(base));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sig_bits  = sig;
    care_bits = care;
    span = (len == '0) ? 1 : ((len > SIG_BYTES) ? SIG_BYTES : len);
  endtask

  // offer one byte, with random idle cycles ahead of it, until it is taken
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= lst;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_region();
    for (int i = 0; i < region.size(); i++)
      send_byte(region[i], i == region.size() - 1);
  endtask

  // random bytes; planted regions carry the signature's cared bytes at a random
  // offset, broken ones the same with one cared byte spoiled
  task automatic build_region(input region_kind_t kind);
    int unsigned rlen;
    int unsigned at;
    int unsigned pick;
    int          cared [$];
    region.delete();
    if (kind == NOISE) rlen = $urandom_range(span + 8, 1);
    else rlen = span + $urandom_range(10, 0);
    for (int i = 0; i < rlen; i++) region = {region, 8'($urandom)};
    if (kind != NOISE) begin
      at = $urandom_range(rlen - span, 0);
      for (int i = 0; i < span; i++)
        if (care_bits[i]) begin
          region[at+i] = sig_bits[i*8 +: 8];
          cared = {cared, i};
        end
      if (kind == BROKEN && cared.size() != 0) begin
        pick = cared[$urandom_range(cared.size() - 1, 0)];
        region[at+pick] = region[at+pick] ^ 8'($urandom_range(255, 1));
      end
    end
  endtask

  // stop offering, wait for every expected result, then stay idle a while longer
  // so nothing is left in flight before any register changes
  task automatic settle();
    int guard;
    guard = 0;
    item_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0 && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off on request, none while calm
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin : stimulus
    logic [LEN_W-1:0]       len;
    logic [SIG_BYTES*8-1:0] sig;
    logic [SIG_BYTES-1:0]   care;
    logic [ADDR_W-1:0]      base;
    int unsigned            roll;
    int                     phase;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset values: length one, nothing cared, so the first byte matches at
    // address zero and the rest of the region stays quiet, final byte too
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    settle();

    // zero length acts as one; match mid region, then match on the final byte
    program_scan(LEN_W'(0), 256'hab, 32'h1, ADDR_W'(48'h1000));
    send_byte(8'h12, 1'b0);
    send_byte(8'hab, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'hab, 1'b1);
    settle();

    // oversize length saturates; all wildcards but too few bytes -> not found
    program_scan(LEN_W'(63), '0, '0, '0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    settle();

    // every byte cared, never lines up -> not found
    program_scan(LEN_W'(2), 256'hffff, 32'h3, '0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    settle();

    // top of the address space: the match address wraps around
    program_scan(LEN_W'(1), 256'h5a, 32'h1, ADDR_MAX);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b1);
    settle();

    // random phases: fresh registers, then a few regions each
    phase = 0;
    while (items_sent < SCAN_ITEMS) begin
      phase++;
      if (phase == 8) begin
        // pressure: single-byte regions that all match while the receiver
        // holds off, so the result register fills and the input stalls
        program_scan(LEN_W'(1), '0, '0, ADDR_W'({$urandom, $urandom}));
        hold_req++;
        repeat (40) send_byte(8'($urandom), 1'b1);
        settle();
        continue;
      end
      calm = (phase == 5);

      roll = $urandom_range(99);
      if (roll < 70) len = LEN_W'($urandom_range(8, 1));
      else if (roll < 90) len = LEN_W'($urandom_range(32, 9));
      else if (roll < 95) len = '0;
      else len = LEN_W'($urandom_range(63, 33));
      for (int w = 0; w < SIG_BYTES / 4; w++) sig[w*32 +: 32] = $urandom;
      roll = $urandom_range(99);
      if (roll < 40) care = $urandom;
      else if (roll < 60) care = '1;
      else if (roll < 70) care = '0;
      else care = $urandom & $urandom;
      if ($urandom_range(9) == 0) base = ADDR_MAX - ADDR_W'($urandom_range(40));
      else base = ADDR_W'({$urandom, $urandom});
      program_scan(len, sig, care, base);

      repeat ($urandom_range(6, 3)) begin
        roll = $urandom_range(99);
        build_region(roll < 60 ? PLANTED : (roll < 85 ? NOISE : BROKEN));
        send_region();
      end
      settle();
      calm = 1'b0;
    end

    settle();
    if (mismatches == 0 && reports_due == 0) begin
      $display("wildcard_byte_pattern_scan_top test passed");
    end else begin
      $display("wildcard_byte_pattern_scan_top test failed");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin : watchdog
    #3_000_000;
    $display("wildcard_byte_pattern_scan_top test failed");
    $finish;
  end

endmodule
